### sv/mtq_pkg.sv
package mtq_pkg;

	// Field and datapath widths
	localparam int RateW   = 16;
	localparam int FieldW  = 16;
	localparam int CoefW   = 16;
	localparam int TickW   = 16;
	localparam int ErrW    = RateW + 1;
	localparam int DiffW   = RateW + 2;
	localparam int SumW    = RateW + 20;
	localparam int TqW     = SumW - 8;
	localparam int CrossW  = FieldW + TqW + 1;
	localparam int MagW    = CrossW;
	localparam int MulAW   = MagW + 1;
	localparam int MulBW   = CoefW + 1;
	localparam int ProdW   = MulAW + MulBW;
	localparam int FracSh  = 12;
	localparam int DvdW    = MagW + CoefW - FracSh;
	localparam int DvsW    = 2 * FieldW;
	localparam int CntW    = $clog2(DvdW + 1);
	localparam int DutyW   = 16;
	localparam int AddrW   = 5;
	localparam int DataW   = 32;

	localparam logic [DutyW-1:0] DutyLimit   = 16'd25600;
	localparam logic [31:0]      GainsReset  = 32'h0100_0200;
	localparam logic [CoefW-1:0] ScaleResetX = 16'd22257;
	localparam logic [CoefW-1:0] ScaleResetY = 16'd22257;
	localparam logic [CoefW-1:0] ScaleResetZ = 16'd23821;

	// Register index, taken from paddr word address
	typedef enum logic [2:0] {
		REG_GAINS_X = 3'd0,
		REG_GAINS_Y = 3'd1,
		REG_GAINS_Z = 3'd2,
		REG_SCALE_X = 3'd3,
		REG_SCALE_Y = 3'd4,
		REG_SCALE_Z = 3'd5
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DE_START,
		S_DE_WAIT,
		S_MUL_P,
		S_MUL_D,
		S_TQ,
		S_BSQ,
		S_BSQ_END,
		S_CRA,
		S_CRB,
		S_CRC,
		S_DM,
		S_DS,
		S_DW,
		S_OUT
	} state_t;

	typedef struct packed {
		logic            start;
		logic [CntW-1:0] count;
		logic [DvdW-1:0] dividend;
		logic [DvsW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [DvdW-1:0] quotient;
	} div_rsp_t;

endpackage

### sv/magnetorquer_pd_duty_controller.sv
// One transaction at a time: the first sample skips the derivative division and a zero
// field skips the cross product and duty division; a new input is taken only in the
// idle state that follows once the result leaves.
// Throughput is set by the shared restoring divider (one quotient bit per
// cycle: 18 bits per derivative, 49 bits per duty) and the shared multiplier.
// Reset clears the sequencer, restores register defaults, zeroes the error
// history and marks the next sample as the first.
module magnetorquer_pd_duty_controller (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [mtq_pkg::AddrW-1:0]          paddr,
	input  logic [mtq_pkg::DataW-1:0]          pwdata,
	output logic [mtq_pkg::DataW-1:0]          prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [mtq_pkg::RateW-1:0]   rate_meas_x,
	input  logic signed [mtq_pkg::RateW-1:0]   rate_meas_y,
	input  logic signed [mtq_pkg::RateW-1:0]   rate_meas_z,
	input  logic signed [mtq_pkg::RateW-1:0]   rate_target_x,
	input  logic signed [mtq_pkg::RateW-1:0]   rate_target_y,
	input  logic signed [mtq_pkg::RateW-1:0]   rate_target_z,
	input  logic signed [mtq_pkg::FieldW-1:0]  field_x,
	input  logic signed [mtq_pkg::FieldW-1:0]  field_y,
	input  logic signed [mtq_pkg::FieldW-1:0]  field_z,
	input  logic [mtq_pkg::TickW-1:0]          interval_ticks,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [mtq_pkg::DutyW-1:0]   duty_x,
	output logic signed [mtq_pkg::DutyW-1:0]   duty_y,
	output logic signed [mtq_pkg::DutyW-1:0]   duty_z,
	output logic [2:0]                         saturated_mask,
	output logic                               field_zero
);

	mtq_pkg::state_t state_q, state_next;

	logic [31:0]                       gains_q [3];
	logic [mtq_pkg::CoefW-1:0]         scale_q [3];

	logic signed [mtq_pkg::ErrW-1:0]   err_q   [3];
	logic signed [mtq_pkg::ErrW-1:0]   prev_q  [3];
	logic signed [mtq_pkg::DiffW-1:0]  de_q    [3];
	logic signed [mtq_pkg::TqW-1:0]    tq_q    [3];
	logic signed [mtq_pkg::FieldW-1:0] b_q     [3];
	logic signed [mtq_pkg::CrossW-1:0] cross_q [3];
	logic signed [mtq_pkg::DutyW-1:0]  duty_q  [3];
	logic [2:0]                        sat_q;
	logic                              fz_q;
	logic                              first_q;
	logic [mtq_pkg::TickW-1:0]         dt_q;
	logic signed [mtq_pkg::CrossW-1:0] acc_q;
	logic [mtq_pkg::DvsW-1:0]          bsq_q;
	logic [1:0]                        ax_q;

	logic                              ax_last;
	logic [1:0]                        ax_nxt;
	logic [1:0]                        ax_j;
	logic [1:0]                        ax_k;
	logic                              accept;
	logic                              cfg_wr;
	logic [2:0]                        cfg_idx;

	logic signed [mtq_pkg::MulAW-1:0]  mul_a;
	logic signed [mtq_pkg::MulBW-1:0]  mul_b;
	logic signed [mtq_pkg::ProdW-1:0]  prod_s1;
	mtq_pkg::div_req_t                 div_req;
	mtq_pkg::div_rsp_t                 div_rsp;

	logic signed [mtq_pkg::DiffW-1:0]  diff_c;
	logic                              diff_neg;
	logic [mtq_pkg::DiffW-1:0]         diff_mag;
	logic [mtq_pkg::DiffW-1:0]         de_mag;
	logic signed [mtq_pkg::SumW-1:0]   sum_c;
	logic signed [mtq_pkg::TqW-1:0]    tq_c;
	logic                              cross_neg;
	logic [mtq_pkg::MagW-1:0]          cross_mag;
	logic                              clip_c;
	logic [mtq_pkg::DutyW-1:0]         duty_mag;

	mtq_mul u_mul (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.prod_s1 (prod_s1)
	);

	mtq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// APB register port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q[0] <= mtq_pkg::GainsReset;
			gains_q[1] <= mtq_pkg::GainsReset;
			gains_q[2] <= mtq_pkg::GainsReset;
			scale_q[0] <= mtq_pkg::ScaleResetX;
			scale_q[1] <= mtq_pkg::ScaleResetY;
			scale_q[2] <= mtq_pkg::ScaleResetZ;
		end else if (cfg_wr) begin
			case (cfg_idx)
				mtq_pkg::REG_GAINS_X: gains_q[0] <= pwdata;
				mtq_pkg::REG_GAINS_Y: gains_q[1] <= pwdata;
				mtq_pkg::REG_GAINS_Z: gains_q[2] <= pwdata;
				mtq_pkg::REG_SCALE_X: scale_q[0] <= pwdata[mtq_pkg::CoefW-1:0];
				mtq_pkg::REG_SCALE_Y: scale_q[1] <= pwdata[mtq_pkg::CoefW-1:0];
				mtq_pkg::REG_SCALE_Z: scale_q[2] <= pwdata[mtq_pkg::CoefW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			mtq_pkg::REG_GAINS_X: prdata = gains_q[0];
			mtq_pkg::REG_GAINS_Y: prdata = gains_q[1];
			mtq_pkg::REG_GAINS_Z: prdata = gains_q[2];
			mtq_pkg::REG_SCALE_X: prdata = mtq_pkg::DataW'(scale_q[0]);
			mtq_pkg::REG_SCALE_Y: prdata = mtq_pkg::DataW'(scale_q[1]);
			mtq_pkg::REG_SCALE_Z: prdata = mtq_pkg::DataW'(scale_q[2]);
			default:              prdata = '0;
		endcase
	end

	// Axis walk and cross-product operand order
	assign ax_last = (ax_q == 2'd2);
	assign ax_nxt  = ax_last ? 2'd0 : ax_q + 2'd1;

	always_comb begin
		unique case (ax_q)
			2'd0:    begin ax_j = 2'd1; ax_k = 2'd2; end
			2'd1:    begin ax_j = 2'd2; ax_k = 2'd0; end
			default: begin ax_j = 2'd0; ax_k = 2'd1; end
		endcase
	end

	// Derivative: signed difference against the stored error
	always_comb begin
		diff_c   = mtq_pkg::DiffW'(err_q[ax_q]) - mtq_pkg::DiffW'(prev_q[ax_q]);
		diff_neg = diff_c[mtq_pkg::DiffW-1];
		diff_mag = diff_neg ? mtq_pkg::DiffW'(-diff_c) : mtq_pkg::DiffW'(diff_c);
		de_mag   = div_rsp.quotient[mtq_pkg::DiffW-1:0];
	end

	// Torque: P*e + D*de, divided by 256 toward zero
	always_comb begin
		sum_c = mtq_pkg::SumW'(acc_q) + mtq_pkg::SumW'(prod_s1);
		tq_c  = sum_c[mtq_pkg::SumW-1:8]
			+ mtq_pkg::TqW'(sum_c[mtq_pkg::SumW-1] && (sum_c[7:0] != 8'd0));
	end

	// Duty: magnitude from quotient, clip, then restore the sign
	always_comb begin
		cross_neg = cross_q[ax_q][mtq_pkg::CrossW-1];
		cross_mag = cross_neg ? mtq_pkg::MagW'(-cross_q[ax_q])
			: mtq_pkg::MagW'(cross_q[ax_q]);
		clip_c    = (div_rsp.quotient > mtq_pkg::DvdW'(mtq_pkg::DutyLimit));
		duty_mag  = clip_c ? mtq_pkg::DutyLimit : div_rsp.quotient[mtq_pkg::DutyW-1:0];
	end

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			mtq_pkg::S_IDLE:     if (in_valid) state_next = mtq_pkg::S_DE_START;
			mtq_pkg::S_DE_START: state_next = first_q ? mtq_pkg::S_MUL_P : mtq_pkg::S_DE_WAIT;
			mtq_pkg::S_DE_WAIT:  if (div_rsp.done) state_next = mtq_pkg::S_MUL_P;
			mtq_pkg::S_MUL_P:    state_next = mtq_pkg::S_MUL_D;
			mtq_pkg::S_MUL_D:    state_next = mtq_pkg::S_TQ;
			mtq_pkg::S_TQ: begin
				if (!ax_last)  state_next = mtq_pkg::S_DE_START;
				else if (fz_q) state_next = mtq_pkg::S_OUT;
				else           state_next = mtq_pkg::S_BSQ;
			end
			mtq_pkg::S_BSQ:      if (ax_last) state_next = mtq_pkg::S_BSQ_END;
			mtq_pkg::S_BSQ_END:  state_next = mtq_pkg::S_CRA;
			mtq_pkg::S_CRA:      state_next = mtq_pkg::S_CRB;
			mtq_pkg::S_CRB:      state_next = mtq_pkg::S_CRC;
			mtq_pkg::S_CRC:      state_next = ax_last ? mtq_pkg::S_DM : mtq_pkg::S_CRA;
			mtq_pkg::S_DM:       state_next = mtq_pkg::S_DS;
			mtq_pkg::S_DS:       state_next = mtq_pkg::S_DW;
			mtq_pkg::S_DW: begin
				if (div_rsp.done) state_next = ax_last ? mtq_pkg::S_OUT : mtq_pkg::S_DM;
			end
			mtq_pkg::S_OUT:      if (!out_stall) state_next = mtq_pkg::S_IDLE;
			default:             state_next = mtq_pkg::S_IDLE;
		endcase
	end

	// Outputs of the sequencer: handshake, multiplier operands, divider request
	always_comb begin
		in_stall = (state_q != mtq_pkg::S_IDLE);
		out_valid = (state_q == mtq_pkg::S_OUT);
		mul_a = '0;
		mul_b = '0;
		div_req = '0;
		unique case (state_q)
			mtq_pkg::S_DE_START: begin
				div_req.start    = !first_q;
				div_req.count    = mtq_pkg::CntW'(mtq_pkg::DiffW);
				div_req.dividend = mtq_pkg::DvdW'(diff_mag) << (mtq_pkg::DvdW - mtq_pkg::DiffW);
				div_req.divisor  = mtq_pkg::DvsW'(dt_q);
			end
			mtq_pkg::S_MUL_P: begin
				mul_a = mtq_pkg::MulAW'(err_q[ax_q]);
				mul_b = {1'b0, gains_q[ax_q][31:16]};
			end
			mtq_pkg::S_MUL_D: begin
				mul_a = mtq_pkg::MulAW'(de_q[ax_q]);
				mul_b = {1'b0, gains_q[ax_q][15:0]};
			end
			mtq_pkg::S_BSQ: begin
				mul_a = mtq_pkg::MulAW'(b_q[ax_q]);
				mul_b = mtq_pkg::MulBW'(b_q[ax_q]);
			end
			mtq_pkg::S_CRA: begin
				mul_a = mtq_pkg::MulAW'(tq_q[ax_k]);
				mul_b = mtq_pkg::MulBW'(b_q[ax_j]);
			end
			mtq_pkg::S_CRB: begin
				mul_a = mtq_pkg::MulAW'(tq_q[ax_j]);
				mul_b = mtq_pkg::MulBW'(b_q[ax_k]);
			end
			mtq_pkg::S_DM: begin
				mul_a = {1'b0, cross_mag};
				mul_b = {1'b0, scale_q[ax_q]};
			end
			mtq_pkg::S_DS: begin
				div_req.start    = 1'b1;
				div_req.count    = mtq_pkg::CntW'(mtq_pkg::DvdW);
				div_req.dividend = mtq_pkg::DvdW'(prod_s1[mtq_pkg::ProdW-1:mtq_pkg::FracSh]);
				div_req.divisor  = bsq_q;
			end
			default: ;
		endcase
	end

	assign accept = (state_q == mtq_pkg::S_IDLE) && in_valid;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mtq_pkg::S_IDLE;
			ax_q       <= 2'd0;
			first_q    <= 1'b1;
			prev_q[0]  <= '0;
			prev_q[1]  <= '0;
			prev_q[2]  <= '0;
		end else begin
			state_q <= state_next;
			if (accept) ax_q <= 2'd0;
			if (state_q == mtq_pkg::S_TQ) begin
				prev_q[ax_q] <= err_q[ax_q];
				ax_q         <= ax_nxt;
				if (ax_last) first_q <= 1'b0;
			end
			if (state_q == mtq_pkg::S_BSQ || state_q == mtq_pkg::S_CRC) ax_q <= ax_nxt;
			if (state_q == mtq_pkg::S_DW && div_rsp.done) ax_q <= ax_nxt;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			err_q[0] <= mtq_pkg::ErrW'(rate_target_x) - mtq_pkg::ErrW'(rate_meas_x);
			err_q[1] <= mtq_pkg::ErrW'(rate_target_y) - mtq_pkg::ErrW'(rate_meas_y);
			err_q[2] <= mtq_pkg::ErrW'(rate_target_z) - mtq_pkg::ErrW'(rate_meas_z);
			b_q[0]   <= field_x;
			b_q[1]   <= field_y;
			b_q[2]   <= field_z;
			dt_q     <= (interval_ticks == '0) ? mtq_pkg::TickW'(1) : interval_ticks;
			fz_q     <= (field_x == '0) && (field_y == '0) && (field_z == '0);
			duty_q[0] <= '0;
			duty_q[1] <= '0;
			duty_q[2] <= '0;
			sat_q    <= '0;
		end
		unique case (state_q)
			mtq_pkg::S_DE_START: if (first_q) de_q[ax_q] <= '0;
			mtq_pkg::S_DE_WAIT: begin
				if (div_rsp.done)
					de_q[ax_q] <= diff_neg ? -$signed(de_mag) : $signed(de_mag);
			end
			mtq_pkg::S_MUL_D:  acc_q <= mtq_pkg::CrossW'(prod_s1);
			mtq_pkg::S_TQ:     tq_q[ax_q] <= tq_c;
			mtq_pkg::S_BSQ: begin
				if (ax_q == 2'd0) bsq_q <= '0;
				else bsq_q <= bsq_q + mtq_pkg::DvsW'(prod_s1);
			end
			mtq_pkg::S_BSQ_END: bsq_q <= bsq_q + mtq_pkg::DvsW'(prod_s1);
			mtq_pkg::S_CRB:    acc_q <= mtq_pkg::CrossW'(prod_s1);
			mtq_pkg::S_CRC:    cross_q[ax_q] <= acc_q - mtq_pkg::CrossW'(prod_s1);
			mtq_pkg::S_DW: begin
				if (div_rsp.done) begin
					duty_q[ax_q] <= cross_neg ? -$signed(duty_mag) : $signed(duty_mag);
					sat_q[ax_q]  <= clip_c;
				end
			end
			default: ;
		endcase
	end

	assign duty_x         = duty_q[0];
	assign duty_y         = duty_q[1];
	assign duty_z         = duty_q[2];
	assign saturated_mask = sat_q;
	assign field_zero     = fz_q;

endmodule

### sv/mtq_mul.sv
module mtq_mul (
	input  logic                              clk,
	input  logic signed [mtq_pkg::MulAW-1:0]  a,
	input  logic signed [mtq_pkg::MulBW-1:0]  b,
	output logic signed [mtq_pkg::ProdW-1:0]  prod_s1
);

	// Register the product of the shared multiplier
	always_ff @(posedge clk) begin
		prod_s1 <= mtq_pkg::ProdW'(a) * mtq_pkg::ProdW'(b);
	end

endmodule

### sv/mtq_div.sv
module mtq_div (
	input  logic               clk,
	input  logic               arst_n,
	input  mtq_pkg::div_req_t  req,
	output mtq_pkg::div_rsp_t  rsp
);

	logic                        busy_q;
	logic                        done_q;
	logic [mtq_pkg::CntW-1:0]    cnt_q;
	logic [mtq_pkg::DvsW-1:0]    rem_q;
	logic [mtq_pkg::DvsW-1:0]    dvs_q;
	logic [mtq_pkg::DvdW-1:0]    quo_q;
	logic [mtq_pkg::DvsW:0]      shifted;
	logic [mtq_pkg::DvsW:0]      trial;
	logic                        ge;
	logic [mtq_pkg::DvsW-1:0]    rem_next;

	// One restoring step: bring down the next dividend bit, subtract if it fits
	always_comb begin
		shifted  = {rem_q, quo_q[mtq_pkg::DvdW-1]};
		trial    = shifted - {1'b0, dvs_q};
		ge       = (shifted >= {1'b0, dvs_q});
		rem_next = ge ? trial[mtq_pkg::DvsW-1:0] : shifted[mtq_pkg::DvsW-1:0];
	end

	// Control: run count steps, pulse done after the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.count;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == mtq_pkg::CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvs_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[mtq_pkg::DvdW-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

### sv/mtq_checker.sv
module mtq_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [15:0] duty_x,
	input  logic signed [15:0] duty_y,
	input  logic signed [15:0] duty_z,
	input  logic [2:0]         saturated_mask,
	input  logic               field_zero
);

	// Hold off new transactions once one is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a transaction is in flight");

	// No input while a result waits
	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

	// Zero field forces zero duties and no clip flags
	a_field_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_zero |->
			duty_x == 16'sd0 && duty_y == 16'sd0 && duty_z == 16'sd0 &&
			saturated_mask == 3'd0)
		else $error("nonzero duty with zero field");

	// A clipped x axis sits exactly at the limit
	a_clip_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated_mask[0] |->
			duty_x == 16'sd25600 || duty_x == -16'sd25600)
		else $error("x clip flag without limit value");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(duty_x) && $stable(saturated_mask))
		else $error("stalled result changed");

endmodule

bind magnetorquer_pd_duty_controller mtq_checker u_mtq_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.duty_x         (duty_x),
	.duty_y         (duty_y),
	.duty_z         (duty_z),
	.saturated_mask (saturated_mask),
	.field_zero     (field_zero)
);
